// ----- rtl/bracket_key_value_frame_parser_defines.svh -----
// Assertion macros for the frame parser RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef BRACKET_KEY_VALUE_FRAME_PARSER_DEFINES_SVH
`define BRACKET_KEY_VALUE_FRAME_PARSER_DEFINES_SVH

`ifndef ASSERT_OFF
// Check held outside reset.
`define BKV_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);
// Check held at every edge, reset included.
`define BKV_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define BKV_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define BKV_ASSERT_ALWAYS(lbl, clk_s, prop, msg)
`endif

`endif

// ----- rtl/bkv_pkg.sv -----
package bkv_pkg;

  // Default content capacity of one frame
  localparam int MAX_CONTENT_DEF = 63;

  // Framing and class characters
  localparam logic [7:0] OPEN_MARK  = 8'h5B;
  localparam logic [7:0] CLOSE_MARK = 8'h5D;
  localparam logic [7:0] SEP_MARK   = 8'h3A;
  localparam logic [7:0] PRINT_LOW  = 8'h20;
  localparam logic [7:0] PRINT_HIGH = 8'h7E;

  typedef enum logic {
    COL_IDLE,
    COL_OPEN
  } col_state_t;

  typedef enum logic {
    EMIT_IDLE,
    EMIT_RUN
  } emit_state_t;

  // Address width of a store of the given depth (at least one bit)
  function automatic int addr_w(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

// ----- rtl/bkv_if.sv -----
// Input byte channel
interface bkv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

// Result character channel
interface bkv_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       in_value_part;
  logic       is_separator;
  logic       last;

  modport source (output valid, output out_char, output in_value_part,
                  output is_separator, output last, input ready);
  modport sink (input valid, input out_char, input in_value_part,
                input is_separator, input last, output ready);
endinterface

// ----- rtl/bracket_key_value_frame_parser.sv -----
// Bracket key/value frame parser.
// in_ch takes one raw byte per transaction (valid/ready). Bytes between '['
// and the first ']' are collected into an on-chip store; a frame that is
// empty, holds more than MAX_CONTENT bytes or any byte outside 0x20..0x7E is
// dropped at its ']'. A valid frame is replayed on out_ch one character per
// transaction, tagged as key, separator (first ':') or value, with last on
// its final character.
// Throughput: one input byte per cycle while collecting. After the ']' of a
// valid frame in_ch.ready stays low while the frame is read back; each
// character is read from the store into a read data register and then moved
// into the output register, one per cycle while out_ch.ready is high.
// The single read port of the content store sets this rate.
// When out_ch.ready is low the read-back pauses, the last character waits in
// the output register, and in_ch is open again once it holds the last one.
// Reset (rst, synchronous) leaves the parser outside any frame with nothing
// pending; the store itself is not cleared and needs no clearing pass.
`include "bracket_key_value_frame_parser_defines.svh"

module bracket_key_value_frame_parser #(
  parameter int MAX_CONTENT = bkv_pkg::MAX_CONTENT_DEF
) (
  input  logic      clk,
  input  logic      rst,
  bkv_in_if.sink    in_ch,
  bkv_out_if.source out_ch
);

  localparam int AW = bkv_pkg::addr_w(MAX_CONTENT);
  localparam int LW = $clog2(MAX_CONTENT + 1);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [6:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [6:0]    mem_rdata;
  logic          emit_start;
  logic [LW-1:0] emit_len;
  logic          emit_busy;

  bkv_collect #(
    .MAX_CONTENT(MAX_CONTENT),
    .AW(AW),
    .LW(LW)
  ) u_collect (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .emit_busy(emit_busy),
    .mem_we(mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .start(emit_start),
    .start_len(emit_len)
  );

  bkv_store #(
    .DEPTH(MAX_CONTENT),
    .AW(AW)
  ) u_store (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re(mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  bkv_emit #(
    .AW(AW),
    .LW(LW)
  ) u_emit (
    .clk(clk),
    .rst(rst),
    .start(emit_start),
    .start_len(emit_len),
    .busy(emit_busy),
    .mem_re(mem_re),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata),
    .out_ch(out_ch)
  );

  // Store is never written during read-back
  `BKV_ASSERT(a_no_write_in_emit, clk, rst, mem_we |-> !emit_busy, "store write during emit")
  // A new frame only starts when the emitter is free
  `BKV_ASSERT(a_start_idle, clk, rst, emit_start |-> !emit_busy, "frame start while emitting")
  // When the last character enters the output register the emitter is done
  `BKV_ASSERT(a_last_done, clk, rst, $rose(out_ch.valid && out_ch.last) |-> !emit_busy,
              "emitter busy after last character")
  // Separator and value tags are exclusive
  `BKV_ASSERT(a_tag_excl, clk, rst,
              out_ch.valid |-> !(out_ch.is_separator && out_ch.in_value_part),
              "separator tagged as value")

endmodule

// ----- rtl/bkv_store.sv -----
// Frame content memory: one write port, one registered read port
module bkv_store #(
  parameter int DEPTH = bkv_pkg::MAX_CONTENT_DEF,
  parameter int AW    = bkv_pkg::addr_w(bkv_pkg::MAX_CONTENT_DEF)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [6:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [6:0]    rdata
);

  logic [6:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/bkv_collect.sv -----
// Frame collector: tracks brackets, checks content, writes the store
module bkv_collect #(
  parameter int MAX_CONTENT = bkv_pkg::MAX_CONTENT_DEF,
  parameter int AW          = bkv_pkg::addr_w(bkv_pkg::MAX_CONTENT_DEF),
  parameter int LW          = $clog2(bkv_pkg::MAX_CONTENT_DEF + 1)
) (
  input  logic          clk,
  input  logic          rst,
  bkv_in_if.sink        in_ch,
  input  logic          emit_busy,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output logic [6:0]    mem_wdata,
  output logic          start,
  output logic [LW-1:0] start_len
);

  localparam logic [LW-1:0] LEN_MAX = LW'(MAX_CONTENT);

  bkv_pkg::col_state_t state, state_next;
  logic [LW-1:0] len, len_next;
  logic          spoiled, spoiled_next;
  logic          accept;
  logic          printable;

  assign in_ch.ready = !emit_busy;
  assign accept      = in_ch.valid && in_ch.ready;
  assign printable   = (in_ch.in_byte >= bkv_pkg::PRINT_LOW) &&
                       (in_ch.in_byte <= bkv_pkg::PRINT_HIGH);

  assign mem_waddr = len[AW-1:0];
  assign mem_wdata = in_ch.in_byte[6:0];
  assign start_len = len;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= bkv_pkg::COL_IDLE;
      len     <= '0;
      spoiled <= 1'b0;
    end else begin
      state   <= state_next;
      len     <= len_next;
      spoiled <= spoiled_next;
    end
  end

  // Next state, store write and emit start
  always_comb begin
    state_next   = state;
    len_next     = len;
    spoiled_next = spoiled;
    mem_we       = 1'b0;
    start        = 1'b0;
    case (state)
      bkv_pkg::COL_IDLE: begin
        if (accept && in_ch.in_byte == bkv_pkg::OPEN_MARK) begin
          state_next   = bkv_pkg::COL_OPEN;
          len_next     = '0;
          spoiled_next = 1'b0;
        end
      end
      bkv_pkg::COL_OPEN: begin
        if (accept) begin
          if (in_ch.in_byte == bkv_pkg::CLOSE_MARK) begin
            state_next   = bkv_pkg::COL_IDLE;
            start        = !spoiled && (len != '0);
            len_next     = '0;
            spoiled_next = 1'b0;
          end else if (!printable) begin
            spoiled_next = 1'b1;
          end else if (!spoiled) begin
            if (len >= LEN_MAX) begin
              spoiled_next = 1'b1;
            end else begin
              mem_we   = 1'b1;
              len_next = len + 1'b1;
            end
          end
        end
      end
      default: begin
        state_next = bkv_pkg::COL_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/bkv_emit.sv -----
// Emitter: reads a closed frame back from the store and tags each byte
module bkv_emit #(
  parameter int AW = bkv_pkg::addr_w(bkv_pkg::MAX_CONTENT_DEF),
  parameter int LW = $clog2(bkv_pkg::MAX_CONTENT_DEF + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [LW-1:0] start_len,
  output logic          busy,
  output logic          mem_re,
  output logic [AW-1:0] mem_raddr,
  input  logic [6:0]    mem_rdata,
  bkv_out_if.source     out_ch
);

  bkv_pkg::emit_state_t state, state_next;
  logic [LW-1:0] len, len_next;
  logic [LW-1:0] rd_idx, rd_idx_next;
  logic [LW-1:0] out_idx, out_idx_next;
  logic          rd_valid, rd_valid_next;
  logic          past, past_next;
  logic          out_valid, out_valid_next;
  logic          load_out;
  logic          sep;
  logic          is_last;

  assign busy      = (state == bkv_pkg::EMIT_RUN);
  assign mem_raddr = rd_idx[AW-1:0];

  // Read data moves on when the output register is free or being taken
  assign load_out = rd_valid && (!out_valid || out_ch.ready);
  assign sep      = !past && (mem_rdata == bkv_pkg::SEP_MARK[6:0]);
  assign is_last  = (LW'(out_idx + 1'b1) == len);

  assign out_ch.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bkv_pkg::EMIT_IDLE;
      rd_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rd_valid  <= rd_valid_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    len     <= len_next;
    rd_idx  <= rd_idx_next;
    out_idx <= out_idx_next;
    past    <= past_next;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ch.out_char      <= mem_rdata;
      out_ch.in_value_part <= past;
      out_ch.is_separator  <= sep;
      out_ch.last          <= is_last;
    end
  end

  always_comb begin
    state_next     = state;
    len_next       = len;
    rd_idx_next    = rd_idx;
    out_idx_next   = out_idx;
    past_next      = past;
    rd_valid_next  = rd_valid;
    mem_re         = 1'b0;
    out_valid_next = load_out ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid);
    case (state)
      bkv_pkg::EMIT_IDLE: begin
        if (start) begin
          state_next    = bkv_pkg::EMIT_RUN;
          len_next      = start_len;
          rd_idx_next   = '0;
          out_idx_next  = '0;
          past_next     = 1'b0;
          rd_valid_next = 1'b0;
        end
      end
      bkv_pkg::EMIT_RUN: begin
        // Issue the next read when the read data slot frees up
        mem_re = (rd_idx != len) && (!rd_valid || load_out);
        if (mem_re) begin
          rd_idx_next   = rd_idx + 1'b1;
          rd_valid_next = 1'b1;
        end else if (load_out) begin
          rd_valid_next = 1'b0;
        end
        if (load_out) begin
          out_idx_next = out_idx + 1'b1;
          past_next    = past || sep;
          if (is_last) begin
            state_next = bkv_pkg::EMIT_IDLE;
          end
        end
      end
      default: begin
        state_next = bkv_pkg::EMIT_IDLE;
      end
    endcase
  end

endmodule
